// ===== hw/rtl/ffra_pkg.sv =====
package ffra_pkg;

  localparam int POOL_BYTES    = 65536;
  localparam int TABLE_ENTRIES = 64;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int END_W  = SIZE_W + 1;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [END_W-1:0] POOL_END  = END_W'(POOL_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_SHRINK = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [SIZE_W-1:0] sz_t;
  typedef logic [END_W-1:0]  end_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    off_t offset;
    sz_t  size;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    idx_t   rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic [1:0] status;
    off_t       region_offset;
    cnt_t       regions_in_use;
  } result_t;

endpackage

// ===== hw/rtl/ffra_table_ram.sv =====
module ffra_table_ram
  import ffra_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ===== hw/rtl/ffra_ctrl.sv =====
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  sz_t        req_size,
  input  off_t       req_offset,
  output ram_req_t   ram,
  input  entry_t     rd_data,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_FIRST = 4'd1;
  localparam logic [3:0] S_A_SCAN  = 4'd2;
  localparam logic [3:0] S_TAIL    = 4'd3;
  localparam logic [3:0] S_SH_UP   = 4'd4;
  localparam logic [3:0] S_WR_NEW  = 4'd5;
  localparam logic [3:0] S_FIND    = 4'd6;
  localparam logic [3:0] S_SH_DN   = 4'd7;
  localparam logic [3:0] S_RESULT  = 4'd8;

  logic [3:0] state, state_next;
  cnt_t       count, count_next;
  idx_t       idx, idx_next;
  idx_t       pos, pos_next;
  end_t       prev_end, prev_end_next;
  off_t       new_off, new_off_next;
  logic [1:0] status, status_next;
  logic       is_free, is_free_next;
  sz_t        size_q, size_q_next;
  off_t       off_q, off_q_next;

  end_t rd_off_x;
  end_t rd_end;
  logic gap_ok;
  cnt_t idx_p1;
  cnt_t idx_p2;

  assign rd_off_x = {{(END_W-OFF_W){1'b0}}, rd_data.offset};
  assign rd_end   = rd_off_x + {1'b0, rd_data.size};
  // a gap that runs backwards counts as empty
  assign gap_ok   = (rd_off_x >= prev_end) &&
                    ((rd_off_x - prev_end) >= {1'b0, size_q});
  assign idx_p1   = {1'b0, idx} + cnt_t'(1);
  assign idx_p2   = {1'b0, idx} + cnt_t'(2);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res.status         = status;
  assign res.region_offset  = new_off;
  assign res.regions_in_use = count;

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    pos_next      = pos;
    prev_end_next = prev_end;
    new_off_next  = new_off;
    status_next   = status;
    is_free_next  = is_free;
    size_q_next   = size_q;
    off_q_next    = off_q;
    ram.wr_en     = 1'b0;
    ram.wr_addr   = idx;
    ram.wr_data   = rd_data;
    ram.rd_addr   = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          size_q_next  = req_size;
          off_q_next   = req_offset;
          is_free_next = (req_type == REQ_FREE);
          new_off_next = '0;
          idx_next     = '0;
          status_next  = ST_REFUSED;
          case (req_type)
            REQ_ALLOC: begin
              if ((req_size == '0) || (count >= CNT_LIMIT)) begin
                state_next = S_RESULT;
              end else if (count == '0) begin
                prev_end_next = '0;
                state_next    = S_TAIL;
              end else begin
                state_next = S_A_FIRST;
              end
            end
            REQ_FREE, REQ_SHRINK: begin
              if (count == '0) begin
                status_next = ST_NOT_FOUND;
                state_next  = S_RESULT;
              end else begin
                state_next = S_FIND;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end

      S_A_FIRST: begin
        if ({1'b0, rd_data.offset} >= size_q) begin
          pos_next     = '0;
          new_off_next = '0;
          ram.rd_addr  = idx_t'(count - cnt_t'(1));
          idx_next     = idx_t'(count);
          state_next   = S_SH_UP;
        end else begin
          prev_end_next = rd_end;
          idx_next      = idx_t'(1);
          if (count == cnt_t'(1)) begin
            state_next = S_TAIL;
          end else begin
            ram.rd_addr = idx_t'(1);
            state_next  = S_A_SCAN;
          end
        end
      end

      S_A_SCAN: begin
        if (gap_ok) begin
          pos_next     = idx;
          new_off_next = prev_end[OFF_W-1:0];
          ram.rd_addr  = idx_t'(count - cnt_t'(1));
          idx_next     = idx_t'(count);
          state_next   = S_SH_UP;
        end else begin
          prev_end_next = rd_end;
          if (idx_p1 == count) begin
            state_next = S_TAIL;
          end else begin
            ram.rd_addr = idx_p1[IDX_W-1:0];
            idx_next    = idx_p1[IDX_W-1:0];
          end
        end
      end

      S_TAIL: begin
        if ((prev_end + {1'b0, size_q}) < POOL_END) begin
          pos_next     = idx_t'(count);
          new_off_next = prev_end[OFF_W-1:0];
          state_next   = S_WR_NEW;
        end else begin
          status_next = ST_REFUSED;
          state_next  = S_RESULT;
        end
      end

      // read data holds entry idx-1; it moves up to idx
      S_SH_UP: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = idx;
        ram.wr_data = rd_data;
        if ((idx - idx_t'(1)) == pos) begin
          state_next = S_WR_NEW;
        end else begin
          ram.rd_addr = idx - idx_t'(2);
          idx_next    = idx - idx_t'(1);
        end
      end

      S_WR_NEW: begin
        ram.wr_en          = 1'b1;
        ram.wr_addr        = pos;
        ram.wr_data.offset = new_off;
        ram.wr_data.size   = size_q;
        count_next         = count + cnt_t'(1);
        status_next        = ST_DONE;
        state_next         = S_RESULT;
      end

      // next entry is fetched speculatively; free relies on it
      S_FIND: begin
        ram.rd_addr = idx_p1[IDX_W-1:0];
        if (rd_data.offset == off_q) begin
          status_next = ST_DONE;
          if (is_free) begin
            if (idx_p1 < count) begin
              state_next = S_SH_DN;
            end else begin
              count_next = count - cnt_t'(1);
              state_next = S_RESULT;
            end
          end else begin
            if (size_q < rd_data.size) begin
              ram.wr_en        = 1'b1;
              ram.wr_addr      = idx;
              ram.wr_data.size = size_q;
            end
            state_next = S_RESULT;
          end
        end else if (idx_p1 == count) begin
          status_next = ST_NOT_FOUND;
          state_next  = S_RESULT;
        end else begin
          idx_next = idx_p1[IDX_W-1:0];
        end
      end

      // read data holds entry idx+1; it moves down to idx
      S_SH_DN: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = idx;
        ram.wr_data = rd_data;
        if (idx_p2 == count) begin
          count_next = count - cnt_t'(1);
          state_next = S_RESULT;
        end else begin
          ram.rd_addr = idx_p2[IDX_W-1:0];
          idx_next    = idx_p1[IDX_W-1:0];
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx      <= idx_next;
    pos      <= pos_next;
    prev_end <= prev_end_next;
    new_off  <= new_off_next;
    status   <= status_next;
    is_free  <= is_free_next;
    size_q   <= size_q_next;
    off_q    <= off_q_next;
  end

endmodule

// ===== hw/rtl/first_fit_region_allocator_unit.sv =====
// First-fit allocator over a 64 KiB pool, keeping up to 63 regions in a 64-entry
// table sorted by offset, held in a single-port-write, registered-read RAM.
// One request is in flight at a time. The table RAM delivers one entry per
// cycle, so latency follows the number n of entries in the table. Allocate
// scans up to the gap that fits, then moves the entries above it up one at a
// time. Scan and shift together cover the table once. A zero size or a full
// table is refused without a scan. Free and shrink scan to the matching
// entry, and free then closes up the rest. A finished result sits in an output
// register, and the next request can be taken in the cycle after the result
// moves there, while it still waits.
module first_fit_region_allocator_unit
  import ffra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  sz_t        req_size,
  input  off_t       req_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output off_t       region_offset,
  output cnt_t       regions_in_use
);

  ram_req_t ram;
  entry_t   rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  ffra_table_ram u_ram (
    .clk     (clk),
    .req     (ram),
    .rd_data (rd_data)
  );

  ffra_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .req_size   (req_size),
    .req_offset (req_offset),
    .ram        (ram),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      status         <= res.status;
      region_offset  <= res.region_offset;
      regions_in_use <= res.regions_in_use;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (regions_in_use <= CNT_LIMIT))
    else $error("region count beyond table limit");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (region_offset == '0))
    else $error("non-zero offset on failed request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && res_valid && (res.status != ST_DONE))
      |-> (res.regions_in_use == regions_in_use))
    else $error("failed request changed the region count");
`endif

endmodule

// ===== tb/tb.sv =====
import ffra_pkg::*;

// Tracks the expected region table and the results still owed by the allocator
class region_ledger;
  off_t    reg_off  [TABLE_ENTRIES];
  sz_t     reg_size [TABLE_ENTRIES];
  int      live;
  int      peak;
  int      placed;
  int      refused;
  int      missed;
  int      checked;
  int      mismatches;
  result_t results_due[$];

  function new();
    live       = 0;
    peak       = 0;
    placed     = 0;
    refused    = 0;
    missed     = 0;
    checked    = 0;
    mismatches = 0;
  endfunction

  // Apply one accepted request to the table copy and queue the result it owes
  function void note_request(logic [1:0] kind, sz_t size, off_t where);
    result_t     want;
    int          slot;
    int          i;
    int          k;
    logic [31:0] base;
    logic [31:0] gap_end;
    logic [31:0] next_off;
    want.status        = ST_REFUSED;
    want.region_offset = '0;
    slot               = -1;
    base               = '0;
    case (kind)
      REQ_ALLOC: begin
        if (size != 0 && live < TABLE_ENTRIES - 1) begin
          if (live > 0 && reg_off[0] >= size) begin
            slot = 0;
          end else if (live > 0) begin
            for (i = 0; i + 1 < live && slot < 0; i++) begin
              gap_end  = 32'(reg_off[i]) + 32'(reg_size[i]);
              next_off = 32'(reg_off[i + 1]);
              // a gap that runs backwards counts as empty
              if (next_off >= gap_end && next_off - gap_end >= size) begin
                slot = i + 1;
                base = gap_end;
              end
            end
            if (slot < 0) base = 32'(reg_off[live - 1]) + 32'(reg_size[live - 1]);
          end
          // tail only if the new end stays strictly inside the pool
          if (slot < 0 && base + 32'(size) < POOL_BYTES) slot = live;
          if (slot >= 0) begin
            for (k = live; k > slot; k--) begin
              reg_off[k]  = reg_off[k - 1];
              reg_size[k] = reg_size[k - 1];
            end
            reg_off[slot]      = off_t'(base);
            reg_size[slot]     = size;
            live++;
            want.status        = ST_DONE;
            want.region_offset = off_t'(base);
          end
        end
      end
      REQ_FREE, REQ_SHRINK: begin
        for (i = 0; i < live && slot < 0; i++) begin
          if (reg_off[i] == where) slot = i;
        end
        if (slot < 0) begin
          want.status = ST_NOT_FOUND;
        end else begin
          want.status = ST_DONE;
          if (kind == REQ_FREE) begin
            for (k = slot; k + 1 < live; k++) begin
              reg_off[k]  = reg_off[k + 1];
              reg_size[k] = reg_size[k + 1];
            end
            live--;
          end else if (size < reg_size[slot]) begin
            reg_size[slot] = size;
          end
        end
      end
      default: ;
    endcase
    want.regions_in_use = cnt_t'(live);
    if (live > peak) peak = live;
    if (kind == REQ_ALLOC && want.status == ST_DONE) placed++;
    if (want.status == ST_REFUSED) refused++;
    if (want.status == ST_NOT_FOUND) missed++;
    results_due.push_back(want);
  endfunction

  function void check_result(logic [1:0] st, off_t got_off, cnt_t got_cnt);
    result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: result with nothing pending: status %0d offset %0d in use %0d",
               $time, st, got_off, got_cnt);
      mismatches++;
    end else begin
      want = results_due.pop_front();
      checked++;
      if (st !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
        mismatches++;
      end
      if (got_off !== want.region_offset) begin
        $display("%0t: region_offset expected %0d, got %0d",
                 $time, want.region_offset, got_off);
        mismatches++;
      end
      if (got_cnt !== want.regions_in_use) begin
        $display("%0t: regions_in_use expected %0d, got %0d",
                 $time, want.regions_in_use, got_cnt);
        mismatches++;
      end
    end
  endfunction
endclass

module tb;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  sz_t        req_size;
  off_t       req_offset;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  off_t       region_offset;
  cnt_t       regions_in_use;

  region_ledger ledger;
  bit           idle_on;
  int           sink_hold;
  int           sent;

  first_fit_region_allocator_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .req_size       (req_size),
    .req_offset     (req_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .region_offset  (region_offset),
    .regions_in_use (regions_in_use)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(logic [1:0] kind, sz_t size, off_t where);
    int gap;
    in_valid   <= 1'b1;
    req_type   <= kind;
    req_size   <= size;
    req_offset <= where;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(kind, size, where);
    sent++;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (ledger.results_due.size() != 0);
  endtask

  task automatic random_request(mix_t mix);
    int         alloc_pct;
    int         free_pct;
    int         roll;
    int         idx;
    logic [1:0] kind;
    sz_t        size;
    off_t       where;
    alloc_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 10 : 50;
    free_pct  = (mix == MIX_DRAIN) ? 80 : 55;
    size      = sz_t'($urandom_range(0, 131071));
    where     = off_t'($urandom_range(0, 65535));
    kind      = REQ_SHRINK;
    if ($urandom_range(0, 99) < alloc_pct) begin
      kind = REQ_ALLOC;
      roll = $urandom_range(0, 99);
      if (roll < 3) size = '0;
      else if (roll < 8) size = sz_t'($urandom_range(65536, 131071));
      else if (roll < 15) size = sz_t'($urandom_range(1000, 65535));
      else size = sz_t'($urandom_range(1, 900));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) kind = REQ_UNKNOWN;
      else if (roll < 5 + free_pct) kind = REQ_FREE;
      // aim mostly at live regions so frees and shrinks actually land
      if (kind != REQ_UNKNOWN && ledger.live > 0 && $urandom_range(0, 99) < 85) begin
        idx   = $urandom_range(0, ledger.live - 1);
        where = ledger.reg_off[idx];
        if ($urandom_range(0, 3) != 0) size = sz_t'($urandom_range(0, ledger.reg_size[idx]));
      end
    end
    send_request(kind, size, where);
  endtask

  // result side: check, then decide the next ready
  initial begin
    int sink_wait;
    sink_wait = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        ledger.check_result(status, region_offset, regions_in_use);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        sink_wait = pause_len();
        out_ready <= (sink_wait == 0);
      end
    end
  end

  initial begin
    int   blk;
    int   n;
    mix_t mix;
    ledger     = new();
    idle_on    = 1'b1;
    sink_hold  = 0;
    sent       = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_ALLOC;
    req_size   <= '0;
    req_offset <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // edges of the size field on an empty pool
    send_request(REQ_ALLOC, 17'd0, 16'd0);
    send_request(REQ_ALLOC, 17'd65536, 16'd0);
    send_request(REQ_ALLOC, 17'd131071, 16'hFFFF);
    send_request(REQ_ALLOC, 17'd65535, 16'd0);
    send_request(REQ_ALLOC, 17'd1, 16'd0);
    send_request(REQ_SHRINK, 17'd131071, 16'd0);
    send_request(REQ_FREE, 17'd0, 16'd0);
    send_request(REQ_FREE, 17'd0, 16'd0);
    send_request(REQ_SHRINK, 17'd0, 16'hFFFF);
    send_request(REQ_UNKNOWN, 17'd131071, 16'hFFFF);
    // middle insert, shrink to zero and a shared offset
    send_request(REQ_ALLOC, 17'd100, 16'd0);
    send_request(REQ_ALLOC, 17'd200, 16'd0);
    send_request(REQ_ALLOC, 17'd300, 16'd0);
    send_request(REQ_FREE, 17'd0, 16'd100);
    send_request(REQ_ALLOC, 17'd50, 16'd0);
    send_request(REQ_SHRINK, 17'd10, 16'd0);
    send_request(REQ_ALLOC, 17'd20, 16'd0);
    send_request(REQ_SHRINK, 17'd0, 16'd10);
    send_request(REQ_ALLOC, 17'd5, 16'd0);
    send_request(REQ_FREE, 17'd0, 16'd10);
    send_request(REQ_SHRINK, 17'd2, 16'd10);
    send_request(REQ_FREE, 17'd0, 16'd0);
    send_request(REQ_FREE, 17'd0, 16'd10);
    send_request(REQ_FREE, 17'd0, 16'd100);
    send_request(REQ_FREE, 17'd0, 16'd300);
    in_valid <= 1'b0;
    wait_drained();

    for (blk = 0; blk < 8; blk++) begin
      case (blk)
        0, 1, 5: mix = MIX_FILL;
        3, 4, 7: mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      idle_on = (blk % 4 != 1);
      // long receiver hold-off while requests keep coming
      if (blk == 2) sink_hold = 400;
      for (n = 0; n < 60; n++) random_request(mix);
      if (blk == 3) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Ran %0d requests, %0d results checked; table peaked at %0d of %0d entries",
             sent, ledger.checked, ledger.peak, TABLE_ENTRIES - 1);
    $display("Allocations placed %0d, refusals %0d, lookups not found %0d",
             ledger.placed, ledger.refused, ledger.missed);
    if (ledger.mismatches == 0) begin
      $display("first_fit_region_allocator_unit test passed");
    end else begin
      $display("first_fit_region_allocator_unit test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("first_fit_region_allocator_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_table_ram.sv
hw/rtl/ffra_ctrl.sv
hw/rtl/first_fit_region_allocator_unit.sv
tb/tb.sv
